[rtl/ddvr_pkg.sv]
// ddvr_pkg: shared types and constants for the diff drive velocity reference
// no dependencies
package ddvr_pkg;

  localparam int unsigned VelWindowDef  = 30;
  localparam int unsigned RateWindowDef = 40;
  localparam int signed   HeadingEdge   = 203265;

  typedef enum logic [1:0] {
    CfgInvPeriod  = 2'd0,
    CfgSpeedLimit = 2'd1,
    CfgHalfTrack  = 2'd2,
    CfgPlanar     = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StMul,
    StRdWin,
    StUpd,
    StDiv,
    StAxisEnd,
    StRate,
    StSqInit,
    StSqY,
    StSqrt,
    StProd,
    StWheel,
    StOut
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/diff_drive_velocity_reference.sv]
// diff_drive_velocity_reference: top level, sequencer with one shared
// multiplier and one square root step
// depends on ddvr_pkg
//
// usage: one reference sample (pos_x/y/z, heading) is taken per request on
// the input valid/ready channel; one result (three velocities, heading rate,
// two wheel speeds, heading) leaves on the output valid/ready channel.
// from the input request to out_valid_o the block runs four passes
// (difference, window update and a four step reciprocal multiply for the
// boxcar mean), in planar mode then the two squares and the 32 step square
// root, then the wheel product and output.
// in_ready_o is low while busy; a new sample is taken only once the last
// result has left the output register.
// the result sits in an output register; while the receiver stalls the block
// holds it and takes no new sample.
// reset clears the windows, sums, last values and filtered rate; the window
// memories are not cleared, each entry is marked invalid by a valid bit and
// reads as zero until written. configuration registers take their defaults.
// configuration writes are meant for idle periods only.
module diff_drive_velocity_reference #(
  parameter int unsigned VelWindow  = ddvr_pkg::VelWindowDef,
  parameter int unsigned RateWindow = ddvr_pkg::RateWindowDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [18:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] heading_rate_o,
  output logic signed [31:0] wheel_left_o,
  output logic signed [31:0] wheel_right_o,
  output logic signed [18:0] heading_out_o
);
  import ddvr_pkg::*;

  localparam int unsigned VW = (VelWindow > 1) ? $clog2(VelWindow) : 1;
  localparam int unsigned RW = (RateWindow > 1) ? $clog2(RateWindow) : 1;

  // reciprocal of the window length, rounded up, scaled by 2^44
  localparam logic [44:0] VelMagic =
    45'(((64'd1 << 44) + 64'(VelWindow) - 64'd1) / 64'(VelWindow));
  localparam logic [44:0] RateMagic =
    45'(((64'd1 << 44) + 64'(RateWindow) - 64'd1) / 64'(RateWindow));
  localparam logic [37:0] VelLenM1  = 38'(VelWindow - 1);
  localparam logic [37:0] RateLenM1 = 38'(RateWindow - 1);

  // config
  logic [25:0] inv_period_q;
  logic [30:0] speed_limit_q;
  logic [23:0] half_track_q;
  logic        planar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_period_q  <= 26'd6553600;
      speed_limit_q <= 31'd65536;
      half_track_q  <= 24'd12288;
      planar_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInvPeriod:  inv_period_q  <= cfg_data_i[25:0];
        CfgSpeedLimit: speed_limit_q <= cfg_data_i;
        CfgHalfTrack:  half_track_q  <= cfg_data_i[23:0];
        CfgPlanar:     planar_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // window memories
  logic signed [31:0] vwin_mem [3][VelWindow];
  logic signed [31:0] rwin_mem [RateWindow];
  logic [VelWindow-1:0]  vvalid_q [3];
  logic [RateWindow-1:0] rvalid_q;
  logic signed [31:0] win_rd_q;

  state_e state_q, state_d;
  logic [1:0]         axis_q, axis_d;
  logic [VW-1:0]      vslot_q, vslot_d;
  logic [RW-1:0]      rslot_q, rslot_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [31:0] pin_q [3];
  logic signed [18:0] hd_q;
  logic signed [31:0] last_pos_q [3];
  logic signed [18:0] last_hd_q;
  logic signed [37:0] vsum_q [3];
  logic signed [37:0] rsum_q;
  logic signed [31:0] frate_q;
  logic signed [31:0] raw_q, raw_d;
  logic signed [31:0] vel_q [3];
  logic signed [31:0] vel_d;
  logic               rate_phase_q, rate_phase_d;
  // divider: |sum| times the reciprocal, four partial products
  logic [37:0]        dq_q, dq_d;
  logic [82:0]        dacc_q, dacc_d;
  logic               dneg_q, dneg_d;
  // square root
  logic [63:0]        sx_q, sx_d;
  logic [63:0]        sr_q, sr_d;
  logic [63:0]        sb_q, sb_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [32:0] speed_q, speed_d;
  logic               out_valid_q;
  logic signed [31:0] o_vel_q [3];
  logic signed [31:0] o_rate_q, o_wl_q, o_wr_q;
  logic signed [18:0] o_hd_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic signed [63:0] sum_sel, sum_new, quot;
  logic               in_rng;
  logic signed [31:0] clampv;
  logic signed [32:0] lim_s;
  logic [44:0]        magic;
  logic [37:0]        wlen_m1;
  logic [82:0]        dpp;

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    vslot_d      = vslot_q;
    rslot_d      = rslot_q;
    cnt_d        = cnt_q;
    raw_d        = raw_q;
    vel_d        = vel_q[axis_q];
    rate_phase_d = rate_phase_q;
    dq_d         = dq_q;
    dacc_d       = dacc_q;
    dneg_d       = dneg_q;
    sx_d         = sx_q;
    sr_d         = sr_q;
    sb_d         = sb_q;
    prod_d       = prod_q;
    speed_d      = speed_q;
    mul_a        = '0;
    mul_b        = '0;
    dpp          = '0;
    magic        = rate_phase_q ? RateMagic : VelMagic;
    wlen_m1      = rate_phase_q ? RateLenM1 : VelLenM1;
    in_rng       = (hd_q >= -19'sd203265) && (hd_q <= 19'sd203265);
    sum_sel      = rate_phase_q ? 64'(rsum_q) : 64'(vsum_q[axis_q]);
    sum_new      = sum_sel + 64'(raw_q) - 64'(win_rd_q);
    quot         = dneg_q ? -64'(dacc_q[82:44]) : 64'(dacc_q[82:44]);
    lim_s        = {2'b0, speed_limit_q};
    clampv       = quot[31:0];
    if (quot > 64'(lim_s)) clampv = lim_s[31:0];
    else if (quot < -64'(lim_s)) clampv = -lim_s[31:0];
    case (state_q)
      StIdle: begin
        if (in_valid_i && !out_valid_q) begin
          state_d      = StMul;
          axis_d       = '0;
          rate_phase_d = 1'b0;
        end
      end
      StMul: begin
        if (rate_phase_q) begin
          mul_a = 33'(hd_q) - 33'(last_hd_q);
          mul_b = 33'(inv_period_q);
          raw_d = in_rng ? sat32(mul_p >>> 16) : frate_q;
        end else begin
          mul_a = 33'(pin_q[axis_q]) - 33'(last_pos_q[axis_q]);
          mul_b = 33'(inv_period_q);
          raw_d = sat32(mul_p >>> 16);
        end
        state_d = StRdWin;
      end
      StRdWin: state_d = StUpd;
      StUpd: begin
        // a negative sum divides |sum| + n - 1 so that the quotient rounds down
        dneg_d  = sum_new[63];
        dq_d    = sum_new[63] ? 38'(-sum_new) + wlen_m1 : 38'(sum_new);
        dacc_d  = '0;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        mul_a = 33'(cnt_q[1] ? dq_q[37:19] : dq_q[18:0]);
        mul_b = 33'(cnt_q[0] ? magic[44:23] : magic[22:0]);
        case (cnt_q[1:0])
          2'd0:    dpp = 83'(mul_p[41:0]);
          2'd1:    dpp = 83'(mul_p[41:0]) << 23;
          2'd2:    dpp = 83'(mul_p[41:0]) << 19;
          default: dpp = 83'(mul_p[41:0]) << 42;
        endcase
        dacc_d = dacc_q + dpp;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd3) state_d = rate_phase_q ? StRate : StAxisEnd;
      end
      StAxisEnd: begin
        vel_d = clampv;
        if (axis_q == 2'd2) begin
          rate_phase_d = 1'b1;
          vslot_d = (32'(vslot_q) == VelWindow - 1) ? '0 : vslot_q + VW'(1);
        end else begin
          axis_d = axis_q + 2'd1;
        end
        state_d = StMul;
      end
      StRate: begin
        rslot_d = (32'(rslot_q) == RateWindow - 1) ? '0 : rslot_q + RW'(1);
        state_d = planar_q ? StSqInit : StProd;
        speed_d = 33'(vel_q[0]);
      end
      StSqInit: begin
        mul_a   = 33'(vel_q[0]);
        mul_b   = 33'(vel_q[0]);
        sx_d    = mul_p;
        state_d = StSqY;
      end
      StSqY: begin
        mul_a = 33'(vel_q[1]);
        mul_b = 33'(vel_q[1]);
        sx_d  = sx_q + mul_p;
        sr_d  = '0;
        sb_d  = 64'h4000000000000000;
        cnt_d = '0;
        state_d = StSqrt;
      end
      StSqrt: begin
        if (sx_q >= sr_q + sb_q) begin
          sx_d = sx_q - (sr_q + sb_q);
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d  = sb_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) state_d = StProd;
      end
      StProd: begin
        if (planar_q) speed_d = 33'(sr_q[31:0]);
        mul_a  = 33'(frate_q);
        mul_b  = 33'(half_track_q);
        prod_d = mul_p >>> 16;
        state_d = StWheel;
      end
      StWheel: state_d = StOut;
      StOut: begin
        if (!out_valid_q) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRdWin) begin
      if (rate_phase_q) win_rd_q <= rvalid_q[rslot_q] ? rwin_mem[rslot_q] : '0;
      else win_rd_q <= vvalid_q[axis_q][vslot_q] ? vwin_mem[axis_q][vslot_q] : '0;
    end
    if (state_q == StUpd) begin
      if (rate_phase_q) rwin_mem[rslot_q] <= raw_q;
      else vwin_mem[axis_q][vslot_q] <= raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q       <= '0;
      vslot_q      <= '0;
      rslot_q      <= '0;
      cnt_q        <= '0;
      rate_phase_q <= 1'b0;
      last_hd_q    <= '0;
      rsum_q       <= '0;
      frate_q      <= '0;
      rvalid_q     <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_pos_q[i] <= '0;
        vsum_q[i]     <= '0;
        vvalid_q[i]   <= '0;
      end
    end else begin
      axis_q       <= axis_d;
      vslot_q      <= vslot_d;
      rslot_q      <= rslot_d;
      cnt_q        <= cnt_d;
      rate_phase_q <= rate_phase_d;
      if (state_q == StUpd) begin
        if (rate_phase_q) begin
          rsum_q <= sum_new[37:0];
          rvalid_q[rslot_q] <= 1'b1;
        end else begin
          vsum_q[axis_q] <= sum_new[37:0];
          vvalid_q[axis_q][vslot_q] <= 1'b1;
          last_pos_q[axis_q] <= pin_q[axis_q];
        end
      end
      if (state_q == StRate) begin
        frate_q   <= quot[31:0];
        last_hd_q <= hd_q;
      end
      if (state_q == StWheel) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    dq_q    <= dq_d;
    dacc_q  <= dacc_d;
    dneg_q  <= dneg_d;
    sx_q    <= sx_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    prod_q  <= prod_d;
    speed_q <= speed_d;
    vel_q[axis_q] <= vel_d;
    if (state_q == StIdle && in_valid_i && !out_valid_q) begin
      pin_q[0] <= pos_x_i;
      pin_q[1] <= pos_y_i;
      pin_q[2] <= pos_z_i;
      hd_q     <= heading_i;
    end
    if (state_q == StWheel) begin
      for (int i = 0; i < 3; i++) o_vel_q[i] <= vel_q[i];
      o_rate_q <= frate_q;
      o_wl_q   <= sat32(64'(speed_q) - prod_q);
      o_wr_q   <= sat32(64'(speed_q) + prod_q);
      o_hd_q   <= hd_q;
    end
  end

  assign in_ready_o     = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign vel_x_o        = o_vel_q[0];
  assign vel_y_o        = o_vel_q[1];
  assign vel_z_o        = o_vel_q[2];
  assign heading_rate_o = o_rate_q;
  assign wheel_left_o   = o_wl_q;
  assign wheel_right_o  = o_wr_q;
  assign heading_out_o  = o_hd_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_out_after_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWheel) |=> out_valid_o) else $error("result not shown");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(vslot_q) < VelWindow) && (32'(rslot_q) < RateWindow))
    else $error("window slot out of range");

endmodule
